/* design/ppu_pkg.sv */
`timescale 1ns / 1ps

package ppu_pkg;

  localparam int DEF_POOL_DEPTH = 256;

  localparam int OP_W    = 2;
  localparam int POS_W   = 24;
  localparam int VEL_W   = 17;
  localparam int COLOR_W = 32;
  localparam int LIFE_W  = 16;
  localparam int SIZE_W  = 8;
  localparam int DT_W    = 16;
  localparam int IDX_W   = 8;
  localparam int LIVE_W  = 9;
  localparam int PROD_W  = 2 * VEL_W;
  localparam int STEP_W  = 20;

  localparam logic [DT_W-1:0] DRAG_Q16 = 16'd64225;

  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

  typedef enum logic [OP_W-1:0] {
    OP_SPAWN = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_TK_ISSUE,
    ST_TK_EVAL,
    ST_MX,
    ST_MY,
    ST_DX,
    ST_DY,
    ST_WB,
    ST_FIN
  } state_t;

  typedef enum logic {
    MUL_MOVE = 1'b0,
    MUL_DRAG = 1'b1
  } mul_mode_t;

  typedef struct packed {
    logic                    en;
    mul_mode_t               mode;
    logic signed [VEL_W-1:0] vel;
    logic [DT_W-1:0]         coef;
  } mul_req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic [COLOR_W-1:0]      color;
    logic [LIFE_W-1:0]       life;
    logic [SIZE_W-1:0]       size;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic signed [POS_W-1:0] sat_pos(
    input logic signed [POS_W-1:0]  pos,
    input logic signed [STEP_W-1:0] step
  );
    logic signed [POS_W:0] sum;
    sum = {pos[POS_W-1], pos} + {{(POS_W + 1 - STEP_W){step[STEP_W-1]}}, step};
    if (sum[POS_W] != sum[POS_W-1]) begin
      return sum[POS_W] ? POS_MIN : POS_MAX;
    end
    return sum[POS_W-1:0];
  endfunction

endpackage

/* design/ppu_in_if.sv */
`timescale 1ns / 1ps

interface ppu_in_if;
  import ppu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [POS_W-1:0]  spawn_pos_x;
  logic signed [POS_W-1:0]  spawn_pos_y;
  logic signed [VEL_W-1:0]  spawn_vel_x;
  logic signed [VEL_W-1:0]  spawn_vel_y;
  logic [COLOR_W-1:0]       spawn_color;
  logic [LIFE_W-1:0]        spawn_lifetime;
  logic [SIZE_W-1:0]        spawn_size;
  logic [DT_W-1:0]          tick_dt;
  logic [IDX_W-1:0]         read_index;

  modport source (
    output valid, operation, spawn_pos_x, spawn_pos_y, spawn_vel_x, spawn_vel_y,
           spawn_color, spawn_lifetime, spawn_size, tick_dt, read_index,
    input  ready
  );

  modport sink (
    input  valid, operation, spawn_pos_x, spawn_pos_y, spawn_vel_x, spawn_vel_y,
           spawn_color, spawn_lifetime, spawn_size, tick_dt, read_index,
    output ready
  );

endinterface

/* design/ppu_out_if.sv */
`timescale 1ns / 1ps

interface ppu_out_if;
  import ppu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [LIVE_W-1:0]        live_count;
  logic                     spawn_dropped;
  logic                     entry_valid;
  logic signed [POS_W-1:0]  out_pos_x;
  logic signed [POS_W-1:0]  out_pos_y;
  logic [COLOR_W-1:0]       out_color;
  logic [SIZE_W-1:0]        out_size;

  modport source (
    output valid, live_count, spawn_dropped, entry_valid, out_pos_x, out_pos_y,
           out_color, out_size,
    input  ready
  );

  modport sink (
    input  valid, live_count, spawn_dropped, entry_valid, out_pos_x, out_pos_y,
           out_color, out_size,
    output ready
  );

endinterface

/* design/particle_pool_update_top.sv */
`timescale 1ns / 1ps

// Particle pool: keeps up to POOL_DEPTH particles in one RAM of packed entries.
// in_ch carries one operation a beat: spawn appends a particle (or flags it
// dropped when full), tick removes expired particles and ages, moves and
// drags the others, read returns one entry. out_ch carries one result beat
// per operation with the live count after it.
// A tick's per-particle cost is set by the single shared multiplier, used four
// times per survivor, and by the one RAM read port. Only one operation is in
// flight; in_ch.ready is high while the sequencer is idle, also while a
// finished result still waits.
// A result waits in the output register while out_ch.ready is low; the
// sequencer holds its finishing step until the register is free.
// Reset empties the pool (live count zero); RAM contents are not cleared.

module particle_pool_update_top #(
  parameter int POOL_DEPTH = ppu_pkg::DEF_POOL_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  ppu_in_if.sink     in_ch,
  ppu_out_if.source  out_ch
);
  import ppu_pkg::*;

  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int AW = $clog2(POOL_DEPTH);
  localparam int RW = (CW > IDX_W) ? CW : IDX_W + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  op_t op_r, op_nxt;
  logic [DT_W-1:0] dt_r, dt_nxt;
  logic [IDX_W-1:0] ridx_r, ridx_nxt;
  entry_t entry_r, entry_nxt;
  logic signed [POS_W-1:0] px_r, px_nxt;
  logic signed [POS_W-1:0] py_r, py_nxt;
  logic signed [VEL_W-1:0] vx_r, vx_nxt;
  logic drop_r, drop_nxt;
  logic hit_r, hit_nxt;

  logic out_valid_r;
  logic out_load;
  logic [LIVE_W-1:0] live_r;
  logic drop_out_r;
  logic hit_out_r;
  logic signed [POS_W-1:0] opx_r, opy_r;
  logic [COLOR_W-1:0] ocol_r;
  logic [SIZE_W-1:0] osz_r;

  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;

  mul_req_t mul_req;
  logic signed [STEP_W-1:0] mul_res;

  logic in_acc;
  logic [CW-1:0] cnt_m1, i_p1;
  logic [RW-1:0] rd_ext;
  logic rd_hit;
  logic expired;
  logic [CW+LIVE_W-1:0] live_ext;

  ppu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ppu_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .res (mul_res)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cnt_m1      = count_r - CW'(1);
  assign i_p1        = i_r + CW'(1);
  assign rd_ext      = RW'(ridx_r);
  assign rd_hit      = rd_ext < RW'(count_r);
  assign expired     = ram_rdata.life <= dt_r;
  assign live_ext    = {{LIVE_W{1'b0}}, count_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_ch.operation))
            OP_SPAWN: state_nxt = ST_SPAWN;
            OP_TICK:  state_nxt = ST_TK_ISSUE;
            OP_READ:  state_nxt = ST_RD_ISSUE;
            default:  state_nxt = ST_FIN;
          endcase
        end
      end
      ST_SPAWN:    state_nxt = ST_FIN;
      ST_RD_ISSUE: state_nxt = rd_hit ? ST_RD_DATA : ST_FIN;
      ST_RD_DATA:  state_nxt = ST_FIN;
      ST_TK_ISSUE: state_nxt = (i_r < count_r) ? ST_TK_EVAL : ST_FIN;
      ST_TK_EVAL: begin
        if (!expired) begin
          state_nxt = ST_MX;
        end else if (i_r == cnt_m1) begin
          state_nxt = ST_FIN;
        end
      end
      ST_MX:  state_nxt = ST_MY;
      ST_MY:  state_nxt = ST_DX;
      ST_DX:  state_nxt = ST_DY;
      ST_DY:  state_nxt = ST_WB;
      ST_WB:  state_nxt = (i_p1 < count_r) ? ST_TK_EVAL : ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = entry_r;
    ram_re    = 1'b0;
    ram_raddr = '0;
    mul_req   = '0;
    count_nxt = count_r;
    i_nxt     = i_r;
    op_nxt    = op_r;
    dt_nxt    = dt_r;
    ridx_nxt  = ridx_r;
    entry_nxt = entry_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    vx_nxt    = vx_r;
    drop_nxt  = drop_r;
    hit_nxt   = hit_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt          = op_t'(in_ch.operation);
          dt_nxt          = in_ch.tick_dt;
          ridx_nxt        = in_ch.read_index;
          entry_nxt.pos_x = in_ch.spawn_pos_x;
          entry_nxt.pos_y = in_ch.spawn_pos_y;
          entry_nxt.vel_x = in_ch.spawn_vel_x;
          entry_nxt.vel_y = in_ch.spawn_vel_y;
          entry_nxt.color = in_ch.spawn_color;
          entry_nxt.life  = in_ch.spawn_lifetime;
          entry_nxt.size  = in_ch.spawn_size;
          i_nxt           = '0;
          drop_nxt        = 1'b0;
          hit_nxt         = 1'b0;
        end
      end
      ST_SPAWN: begin
        if (count_r == DEPTH_C) begin
          drop_nxt = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = count_r[AW-1:0];
          count_nxt = count_r + CW'(1);
        end
      end
      ST_RD_ISSUE: begin
        hit_nxt   = rd_hit;
        ram_re    = rd_hit;
        ram_raddr = rd_ext[AW-1:0];
      end
      ST_RD_DATA: begin
        entry_nxt = ram_rdata;
      end
      ST_TK_ISSUE: begin
        ram_re    = i_r < count_r;
        ram_raddr = i_r[AW-1:0];
      end
      ST_TK_EVAL: begin
        if (expired) begin
          // pull the last entry into this slot and look at it again
          count_nxt = cnt_m1;
          ram_re    = i_r != cnt_m1;
          ram_raddr = cnt_m1[AW-1:0];
        end else begin
          entry_nxt      = ram_rdata;
          entry_nxt.life = ram_rdata.life - dt_r;
        end
      end
      ST_MX: begin
        mul_req = '{en: 1'b1, mode: MUL_MOVE, vel: entry_r.vel_x, coef: dt_r};
      end
      ST_MY: begin
        mul_req = '{en: 1'b1, mode: MUL_MOVE, vel: entry_r.vel_y, coef: dt_r};
        px_nxt  = sat_pos(entry_r.pos_x, mul_res);
      end
      ST_DX: begin
        mul_req = '{en: 1'b1, mode: MUL_DRAG, vel: entry_r.vel_x, coef: DRAG_Q16};
        py_nxt  = sat_pos(entry_r.pos_y, mul_res);
      end
      ST_DY: begin
        mul_req = '{en: 1'b1, mode: MUL_DRAG, vel: entry_r.vel_y, coef: DRAG_Q16};
        vx_nxt  = mul_res[VEL_W-1:0];
      end
      ST_WB: begin
        ram_we          = 1'b1;
        ram_waddr       = i_r[AW-1:0];
        ram_wdata.pos_x = px_r;
        ram_wdata.pos_y = py_r;
        ram_wdata.vel_x = vx_r;
        ram_wdata.vel_y = mul_res[VEL_W-1:0];
        i_nxt           = i_p1;
        ram_re          = i_p1 < count_r;
        ram_raddr       = i_p1[AW-1:0];
      end
      ST_FIN: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      drop_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    op_r    <= op_nxt;
    dt_r    <= dt_nxt;
    ridx_r  <= ridx_nxt;
    entry_r <= entry_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    vx_r    <= vx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      live_r     <= live_ext[LIVE_W-1:0];
      drop_out_r <= drop_r;
      hit_out_r  <= hit_r;
      opx_r      <= hit_r ? entry_r.pos_x : '0;
      opy_r      <= hit_r ? entry_r.pos_y : '0;
      ocol_r     <= hit_r ? entry_r.color : '0;
      osz_r      <= hit_r ? entry_r.size  : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.live_count    = live_r;
  assign out_ch.spawn_dropped = drop_out_r;
  assign out_ch.entry_valid   = hit_out_r;
  assign out_ch.out_pos_x     = opx_r;
  assign out_ch.out_pos_y     = opy_r;
  assign out_ch.out_color     = ocol_r;
  assign out_ch.out_size      = osz_r;

  a_wb_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> (i_r < count_r))
    else $error("write-back slot beyond live count");

  a_spawn_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPAWN && count_r != DEPTH_C) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("accepted spawn did not grow the pool");

  a_tick_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TK_EVAL) |=> (count_r <= $past(count_r)))
    else $error("tick grew the pool");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result beat raised outside the finishing step");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != ST_IDLE))
    else $error("accepted beat left sequencer idle");

endmodule

/* design/ppu_ram.sv */
`timescale 1ns / 1ps

module ppu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/ppu_mul.sv */
`timescale 1ns / 1ps

module ppu_mul (
  input  logic                            clk,
  input  ppu_pkg::mul_req_t               req,
  output logic signed [ppu_pkg::STEP_W-1:0] res
);
  import ppu_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  mul_mode_t                mode_r;
  logic signed [PROD_W:0]   rnd;

  assign prod_nxt = PROD_W'(req.vel) * PROD_W'($signed({1'b0, req.coef}));

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
      mode_r <= req.mode;
    end
  end

  // round to nearest, then floor shift
  always_comb begin
    rnd = {prod_r[PROD_W-1], prod_r};
    case (mode_r)
      MUL_MOVE: begin
        rnd = rnd + (PROD_W + 1)'(1 << 14);
        res = STEP_W'(rnd >>> 15);
      end
      MUL_DRAG: begin
        rnd = rnd + (PROD_W + 1)'(1 << 15);
        res = STEP_W'(rnd >>> 16);
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule
